// ===== sv/quaternion_arithmetic_unit_defines.svh =====
// Assertion macros of the quaternion arithmetic unit RTL, used by its queue.
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QAU_ASSERT_IMPL(lbl, ante, cons, msg)
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/qau_pkg.sv =====
// Types, opcodes and fixed-point helpers of the quaternion arithmetic unit.
package qau_pkg;

  localparam int FRAC_BITS_DEF = 28;
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 2;
  localparam int ROOT_STEPS    = 32;
  localparam int QUO_BITS      = 33;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_SCALE = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_CONJ  = 4'd5;
  localparam logic [3:0] OP_INV   = 4'd6;
  localparam logic [3:0] OP_DOT   = 4'd7;
  localparam logic [3:0] OP_ROT   = 4'd8;
  localparam logic [3:0] OP_NORM  = 4'd9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [32:0] s33_t;
  typedef logic signed [63:0] s64_t;
  typedef s33_t [3:0] quad33_t;
  typedef s64_t [3:0] quad64_t;
  typedef quad64_t [3:0] prod_t;

  typedef struct packed {
    logic [3:0] cmd;
    s32_t a_w;
    s32_t a_x;
    s32_t a_y;
    s32_t a_z;
    s32_t b_w;
    s32_t b_x;
    s32_t b_y;
    s32_t b_z;
  } in_t;

  typedef struct packed {
    s32_t r_w;
    s32_t r_x;
    s32_t r_y;
    s32_t r_z;
    logic [1:0] status;
  } out_t;

  // Item handed from the front to the back: finished values or dividends,
  // the truncated norm, and the flags found so far.
  typedef struct packed {
    logic [3:0]  cmd;
    quad33_t     c;
    logic [63:0] n;
    logic        sat;
    logic        zero;
  } mid_t;

  function automatic s33_t sx33(input s32_t v);
    return 33'(v);
  endfunction

  function automatic s64_t sx64(input s33_t v);
    return 64'(v);
  endfunction

  function automatic s64_t mulq(input s33_t x, input s33_t y, input int frac);
    logic signed [65:0] p;
    p = x * y;
    return 64'(p >>> frac);
  endfunction

  function automatic quad64_t hamilton(input prod_t p);
    quad64_t h;
    h[0] = p[0][0] - p[1][1] - p[2][2] - p[3][3];
    h[1] = p[0][1] + p[1][0] + p[2][3] - p[3][2];
    h[2] = p[0][2] - p[1][3] + p[2][0] + p[3][1];
    h[3] = p[0][3] + p[1][2] - p[2][1] + p[3][0];
    return h;
  endfunction

  function automatic logic ovf32(input s64_t v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic s32_t sat32(input s64_t v);
    s32_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== sv/quaternion_arithmetic_unit.sv =====
// Top level of the quaternion arithmetic unit: front, queues and back.

// The unit takes one item per clock while in_full is low and returns one
// result per item, in order. Items are signed fixed-point quaternions with
// FRAC_BITS fraction bits and an opcode; the result carries four components
// and a status code. An item passes the front, where two registered 33 by 33
// bit product arrays and their sums form every product-based result, then
// the middle queue, the back and the output queue. The back length is set by
// the 32 square-root steps that normalize needs and the 33 quotient steps of
// the four divider lanes; every item walks the same path so results stay in
// order. Each pipeline freezes only while its own output queue is full, and
// the queue between them lets the front keep taking transfers while the back
// waits.
module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
  parameter int MID_DEPTH = qau_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = qau_pkg::OUT_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  qau_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output qau_pkg::out_t out_data
);

  logic          mid_push, mid_full, mid_pop, mid_empty;
  qau_pkg::mid_t mid_wdata, mid_rdata;
  logic          res_push, res_full;
  qau_pkg::out_t res_item;

  // Front: decode and product stages.
  qau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_item (mid_wdata)
  );

  // Decoupling queue between front and back.
  qau_fifo #(.T(qau_pkg::mid_t), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .full  (mid_full),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rdata)
  );

  // Back: root and divider lanes, final result selection.
  qau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_item  (mid_rdata),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_item  (res_item)
  );

  // Result queue; its head is what the user sees.
  qau_fifo #(.T(qau_pkg::out_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_item),
    .pop   (out_pop && !out_empty),
    .empty (out_empty),
    .rdata (out_data)
  );

endmodule

// ===== sv/qau_fifo.sv =====
// Small synchronous queue used between the front and back and at the output.
`include "quaternion_arithmetic_unit_defines.svh"

module qau_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  T     wdata,
  input  logic pop,
  output logic empty,
  output T     rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  `QAU_ASSERT_IMPL(a_push_not_full, push, !full, "transfer into a full queue")
  `QAU_ASSERT_IMPL(a_pop_not_empty, pop, !empty, "transfer out of an empty queue")
  `QAU_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after a write")

endmodule

// ===== sv/qau_front.sv =====
// Front pipeline: accepts items, decodes the opcode and runs the product stages.
module qau_front #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  qau_pkg::in_t   in_data,
  input  logic           mid_full,
  output logic           mid_push,
  output qau_pkg::mid_t  mid_item
);

  localparam int NSTG = 7;

  typedef struct packed {
    logic [3:0]       cmd;
    qau_pkg::quad33_t a;
    qau_pkg::quad33_t b;
  } opnd_t;

  typedef struct packed {
    logic [3:0]       cmd;
    qau_pkg::quad33_t a;
    qau_pkg::quad33_t c;
    logic             sat;
    logic [63:0]      n;
  } part_t;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic en;

  qau_pkg::in_t     in_r;
  opnd_t            b_op_r, b_op_nxt;
  qau_pkg::prod_t   b_p_r, b_p_nxt;
  qau_pkg::quad64_t b_sq_r, b_sq_nxt;
  opnd_t            c_op_r;
  qau_pkg::quad64_t c_v_r, c_v_nxt;
  logic [63:0]      c_n_r, c_n_nxt;
  part_t            d_r, d_nxt;
  part_t            e_r;
  qau_pkg::prod_t   e_p_r, e_p_nxt;
  part_t            f_r;
  qau_pkg::quad64_t f_h_r, f_h_nxt;
  qau_pkg::mid_t    g_r, g_nxt;

  qau_pkg::quad33_t aq, bq, yq, src, ca;
  qau_pkg::quad64_t h1;
  qau_pkg::s64_t    nsum;
  logic             raw;

  assign en       = !vld_r[NSTG-1] || !mid_full;
  assign in_full  = !en;
  assign mid_push = vld_r[NSTG-1] && !mid_full;
  assign mid_item = g_r;
  assign vld_nxt  = {vld_r[NSTG-2:0], in_push && en};

  // Operand selection and the first product array.
  always_comb begin
    aq[0] = qau_pkg::sx33(in_r.a_w);
    aq[1] = qau_pkg::sx33(in_r.a_x);
    aq[2] = qau_pkg::sx33(in_r.a_y);
    aq[3] = qau_pkg::sx33(in_r.a_z);
    bq[0] = qau_pkg::sx33(in_r.b_w);
    bq[1] = qau_pkg::sx33(in_r.b_x);
    bq[2] = qau_pkg::sx33(in_r.b_y);
    bq[3] = qau_pkg::sx33(in_r.b_z);
    yq  = bq;
    src = aq;
    if (in_r.cmd == qau_pkg::OP_DIV) begin
      yq[1] = -bq[1];
      yq[2] = -bq[2];
      yq[3] = -bq[3];
      src   = bq;
    end else if (in_r.cmd == qau_pkg::OP_ROT) begin
      yq[0] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        b_p_nxt[i][j] = qau_pkg::mulq(aq[i], yq[j], FRAC_BITS);
      end
      b_sq_nxt[i] = qau_pkg::mulq(src[i], src[i], FRAC_BITS);
    end
    b_op_nxt.cmd = in_r.cmd;
    b_op_nxt.a   = aq;
    b_op_nxt.b   = bq;
  end

  // Per-opcode values: sums of the truncated products, or operand sums and copies.
  always_comb begin
    h1      = qau_pkg::hamilton(b_p_r);
    nsum    = b_sq_r[0] + b_sq_r[1] + b_sq_r[2] + b_sq_r[3];
    c_n_nxt = 64'(nsum);
    c_v_nxt = '0;
    case (b_op_r.cmd)
      qau_pkg::OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          c_v_nxt[i] = qau_pkg::sx64(b_op_r.a[i]) + qau_pkg::sx64(b_op_r.b[i]);
        end
      end
      qau_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          c_v_nxt[i] = qau_pkg::sx64(b_op_r.a[i]) - qau_pkg::sx64(b_op_r.b[i]);
        end
      end
      qau_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          c_v_nxt[i] = b_p_r[i][0];
        end
      end
      qau_pkg::OP_MUL, qau_pkg::OP_DIV, qau_pkg::OP_ROT: begin
        c_v_nxt = h1;
      end
      qau_pkg::OP_CONJ, qau_pkg::OP_INV: begin
        c_v_nxt[0] = qau_pkg::sx64(b_op_r.a[0]);
        for (int i = 1; i < 4; i++) begin
          c_v_nxt[i] = -qau_pkg::sx64(b_op_r.a[i]);
        end
      end
      qau_pkg::OP_DOT: begin
        c_v_nxt[0] = b_p_r[0][0] + b_p_r[1][1] + b_p_r[2][2] + b_p_r[3][3];
      end
      qau_pkg::OP_NORM: begin
        for (int i = 0; i < 4; i++) begin
          c_v_nxt[i] = qau_pkg::sx64(b_op_r.a[i]);
        end
      end
      default: c_v_nxt = '0;
    endcase
  end

  // Saturation; inverse and normalize keep their exact dividends.
  always_comb begin
    raw       = (c_op_r.cmd == qau_pkg::OP_INV) || (c_op_r.cmd == qau_pkg::OP_NORM);
    d_nxt.cmd = c_op_r.cmd;
    d_nxt.a   = c_op_r.a;
    d_nxt.n   = c_n_r;
    d_nxt.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      d_nxt.c[i] = raw ? c_v_r[i][32:0] : qau_pkg::sx33(qau_pkg::sat32(c_v_r[i]));
      d_nxt.sat  = d_nxt.sat | (!raw && qau_pkg::ovf32(c_v_r[i]));
    end
  end

  // Second product array: t * conj(a) for rotate.
  always_comb begin
    ca[0] = d_r.a[0];
    for (int i = 1; i < 4; i++) begin
      ca[i] = -d_r.a[i];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e_p_nxt[i][j] = qau_pkg::mulq(d_r.c[i], ca[j], FRAC_BITS);
      end
    end
  end

  assign f_h_nxt = qau_pkg::hamilton(e_p_r);

  always_comb begin
    g_nxt.cmd  = f_r.cmd;
    g_nxt.n    = f_r.n;
    g_nxt.c    = f_r.c;
    g_nxt.sat  = f_r.sat;
    if (f_r.cmd == qau_pkg::OP_ROT) begin
      g_nxt.c[0] = '0;
      for (int i = 1; i < 4; i++) begin
        g_nxt.c[i] = qau_pkg::sx33(qau_pkg::sat32(f_h_r[i]));
      end
      for (int i = 0; i < 4; i++) begin
        g_nxt.sat = g_nxt.sat | qau_pkg::ovf32(f_h_r[i]);
      end
    end
    g_nxt.zero = (f_r.n == '0) && ((f_r.cmd == qau_pkg::OP_DIV) ||
                 (f_r.cmd == qau_pkg::OP_INV) || (f_r.cmd == qau_pkg::OP_NORM));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r   <= in_data;
      b_op_r <= b_op_nxt;
      b_p_r  <= b_p_nxt;
      b_sq_r <= b_sq_nxt;
      c_op_r <= b_op_r;
      c_v_r  <= c_v_nxt;
      c_n_r  <= c_n_nxt;
      d_r    <= d_nxt;
      e_r    <= d_r;
      e_p_r  <= e_p_nxt;
      f_r    <= e_r;
      f_h_r  <= f_h_nxt;
      g_r    <= g_nxt;
    end
  end

endmodule

// ===== sv/qau_back.sv =====
// Back pipeline: square root for normalize, four divider lanes, result select.
module qau_back #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          mid_empty,
  output logic          mid_pop,
  input  qau_pkg::mid_t mid_item,
  input  logic          out_full,
  output logic          out_push,
  output qau_pkg::out_t out_item
);

  localparam int RS   = qau_pkg::ROOT_STEPS;
  localparam int QB   = qau_pkg::QUO_BITS;
  localparam int NSTG = 1 + RS + 1 + QB + 1;
  localparam logic [63:0] BIG_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;
  localparam logic [31:0] ONE_Q     = 32'(64'd1 << FRAC_BITS);

  typedef struct packed {
    qau_pkg::mid_t it;
    logic [63:0]   v;
    logic [63:0]   root;
  } sq_st_t;

  typedef struct packed {
    qau_pkg::mid_t        it;
    logic [63:0]          d;
    logic [3:0][63:0]     rem;
    logic [3:0][QB-1:0]   q;
    logic [3:0]           ovf;
  } dv_st_t;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic en;

  sq_st_t sq_r [RS+1];
  sq_st_t sq_nxt [RS+1];
  dv_st_t dv_r [QB+1];
  dv_st_t dv_nxt [QB+1];
  qau_pkg::out_t out_r, out_nxt;

  assign en       = !vld_r[NSTG-1] || !out_full;
  assign mid_pop  = en && !mid_empty;
  assign out_push = vld_r[NSTG-1] && !out_full;
  assign out_item = out_r;
  assign vld_nxt  = {vld_r[NSTG-2:0], mid_pop};

  // Radicand: norm shifted up by the fraction, clamped at all ones.
  always_comb begin
    sq_nxt[0].it   = mid_item;
    sq_nxt[0].v    = (mid_item.n > BIG_LIMIT) ? '1 : (mid_item.n << FRAC_BITS);
    sq_nxt[0].root = '0;
  end

  for (genvar j = 0; j < RS; j++) begin : g_root
    localparam int K = RS - 1 - j;
    localparam logic [63:0] ONE_BIT = 64'd1 << (2 * K);
    logic [63:0] trial;
    always_comb begin
      trial = sq_r[j].root + ONE_BIT;
      sq_nxt[j+1] = sq_r[j];
      if (sq_r[j].v >= trial) begin
        sq_nxt[j+1].v    = sq_r[j].v - trial;
        sq_nxt[j+1].root = (sq_r[j].root >> 1) + ONE_BIT;
      end else begin
        sq_nxt[j+1].root = sq_r[j].root >> 1;
      end
    end
  end

  // Divider setup: magnitude of the scaled dividend and an early overflow check.
  logic [3:0][32:0] mag;
  always_comb begin
    dv_nxt[0].it = sq_r[RS].it;
    dv_nxt[0].d  = (sq_r[RS].it.cmd == qau_pkg::OP_NORM) ? sq_r[RS].root : sq_r[RS].it.n;
    dv_nxt[0].q  = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = sq_r[RS].it.c[i][32] ? 33'(-sq_r[RS].it.c[i]) : 33'(sq_r[RS].it.c[i]);
      dv_nxt[0].rem[i] = 64'(mag[i]) << FRAC_BITS;
      dv_nxt[0].ovf[i] = (dv_nxt[0].rem[i] >> QB) >= dv_nxt[0].d;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    always_comb begin
      dv_nxt[j+1] = dv_r[j];
      for (int i = 0; i < 4; i++) begin
        if ((dv_r[j].rem[i] >> K) >= dv_r[j].d) begin
          dv_nxt[j+1].rem[i] = dv_r[j].rem[i] - (dv_r[j].d << K);
          dv_nxt[j+1].q[i][K] = 1'b1;
        end
      end
    end
  end

  // Signed, saturated quotients and the per-opcode result.
  qau_pkg::mid_t    fit;
  logic [3:0][31:0] dq, rq;
  logic             dsat;
  logic [1:0]       st;
  always_comb begin
    fit  = dv_r[QB].it;
    dsat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (dv_r[QB].ovf[i]) begin
        dq[i] = fit.c[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        dsat  = 1'b1;
      end else if (fit.c[i][32]) begin
        if (dv_r[QB].q[i] > 33'h0_8000_0000) begin
          dq[i] = 32'h8000_0000;
          dsat  = 1'b1;
        end else begin
          dq[i] = 32'(-dv_r[QB].q[i]);
        end
      end else if (dv_r[QB].q[i] > 33'h0_7FFF_FFFF) begin
        dq[i] = 32'h7FFF_FFFF;
        dsat  = 1'b1;
      end else begin
        dq[i] = dv_r[QB].q[i][31:0];
      end
    end
    for (int i = 0; i < 4; i++) begin
      rq[i] = fit.c[i][31:0];
    end
    st = fit.sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
    case (fit.cmd)
      qau_pkg::OP_DIV, qau_pkg::OP_NORM, qau_pkg::OP_INV: begin
        if (fit.zero) begin
          rq = '0;
          if (fit.cmd == qau_pkg::OP_INV) begin
            rq[0] = ONE_Q;
          end
          st = qau_pkg::ST_ZERO;
        end else begin
          rq = dq;
          st = (fit.sat || dsat) ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
        end
      end
      default: st = fit.sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
    endcase
    out_nxt.r_w    = rq[0];
    out_nxt.r_x    = rq[1];
    out_nxt.r_y    = rq[2];
    out_nxt.r_z    = rq[3];
    out_nxt.status = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s <= RS; s++) begin
        sq_r[s] <= sq_nxt[s];
      end
      for (int s = 0; s <= QB; s++) begin
        dv_r[s] <= dv_nxt[s];
      end
      out_r <= out_nxt;
    end
  end

endmodule

// ===== tb/sv/qau_result_checker.sv =====
// Result checker for the quaternion arithmetic unit: predicts, queues and compares.
`timescale 1ns / 1ps
module qau_result_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic          in_full,
  input  qau_pkg::in_t  in_data,
  input  logic          out_empty,
  input  logic          out_pop,
  input  qau_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import qau_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  typedef logic signed [63:0] wide_t;
  typedef wide_t [3:0] wquad_t;

  out_t expected_results[$];
  int   mismatch_total = 0;

  assign fail_count = mismatch_total;
  assign pending    = expected_results.size();

  function automatic wide_t qmul(input wide_t x, input wide_t y);
    wide_t p;
    p = x * y;
    return p >>> FB;
  endfunction

  function automatic wide_t clip32(input wide_t v, inout logic sat);
    wide_t r;
    r = v;
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      sat = 1'b1;
      r = -64'sd2147483648;
    end
    return r;
  endfunction

  function automatic wquad_t hprod(input wquad_t a, input wquad_t b, inout logic sat);
    wquad_t r;
    r[0] = clip32(qmul(a[0], b[0]) - qmul(a[1], b[1]) - qmul(a[2], b[2])
                  - qmul(a[3], b[3]), sat);
    r[1] = clip32(qmul(a[0], b[1]) + qmul(a[1], b[0]) + qmul(a[2], b[3])
                  - qmul(a[3], b[2]), sat);
    r[2] = clip32(qmul(a[0], b[2]) - qmul(a[1], b[3]) + qmul(a[2], b[0])
                  + qmul(a[3], b[1]), sat);
    r[3] = clip32(qmul(a[0], b[3]) + qmul(a[1], b[2]) - qmul(a[2], b[1])
                  + qmul(a[3], b[0]), sat);
    return r;
  endfunction

  function automatic wide_t sq_norm(input wquad_t q);
    return qmul(q[0], q[0]) + qmul(q[1], q[1]) + qmul(q[2], q[2]) + qmul(q[3], q[3]);
  endfunction

  // Fixed-point quotient, truncated toward zero; the divisor is positive.
  function automatic wide_t fix_div(input wide_t c, input wide_t d, inout logic sat);
    wide_t q;
    q = (c <<< FB) / d;
    return clip32(q, sat);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic out_t quat_result(input in_t it);
    wquad_t a, b, r, t, c;
    wide_t n;
    logic [63:0] big, m;
    logic sat, zero;
    out_t o;
    a = '{wide_t'(it.a_w), wide_t'(it.a_x), wide_t'(it.a_y), wide_t'(it.a_z)};
    b = '{wide_t'(it.b_w), wide_t'(it.b_x), wide_t'(it.b_y), wide_t'(it.b_z)};
    // The literal order above puts w at index 3; flip so index 0 is w.
    a = '{a[0], a[1], a[2], a[3]};
    b = '{b[0], b[1], b[2], b[3]};
    r = '{default: '0};
    sat = 1'b0;
    zero = 1'b0;
    case (it.cmd)
      OP_ADD:   for (int i = 0; i < 4; i++) r[i] = clip32(a[i] + b[i], sat);
      OP_SUB:   for (int i = 0; i < 4; i++) r[i] = clip32(a[i] - b[i], sat);
      OP_SCALE: for (int i = 0; i < 4; i++) r[i] = clip32(qmul(a[i], b[0]), sat);
      OP_MUL:   r = hprod(a, b, sat);
      OP_DIV: begin
        n = sq_norm(b);
        if (n <= 0) begin
          zero = 1'b1;
        end else begin
          c = '{-b[3], -b[2], -b[1], b[0]};
          t = hprod(a, '{c[3], c[2], c[1], c[0]}, sat);
          for (int i = 0; i < 4; i++) r[i] = fix_div(t[i], n, sat);
        end
      end
      OP_CONJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = clip32(-a[i], sat);
      end
      OP_INV: begin
        n = sq_norm(a);
        if (n <= 0) begin
          zero = 1'b1;
          r[0] = wide_t'(1) <<< FB;
        end else begin
          r[0] = fix_div(a[0], n, sat);
          for (int i = 1; i < 4; i++) r[i] = fix_div(-a[i], n, sat);
        end
      end
      OP_DOT:
        r[0] = clip32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2])
                      + qmul(a[3], b[3]), sat);
      OP_ROT: begin
        c = '{b[3], b[2], b[1], 64'sd0};
        t = hprod(a, '{c[3], c[2], c[1], c[0]}, sat);
        c = '{-a[3], -a[2], -a[1], a[0]};
        r = hprod(t, '{c[3], c[2], c[1], c[0]}, sat);
        r[0] = 0;
      end
      OP_NORM: begin
        n = sq_norm(a);
        if (n <= 0) begin
          zero = 1'b1;
        end else begin
          if (n > 64'sh0000_000F_FFFF_FFFF) big = '1;
          else big = 64'(n) << FB;
          m = int_sqrt(big);
          for (int i = 0; i < 4; i++) r[i] = fix_div(a[i], wide_t'(m), sat);
        end
      end
      default: ;
    endcase
    o.r_w = r[0][31:0];
    o.r_x = r[1][31:0];
    o.r_y = r[2][31:0];
    o.r_z = r[3][31:0];
    o.status = zero ? ST_ZERO : (sat ? ST_SAT : ST_OK);
    return o;
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n) begin
      if (in_push && !in_full) expected_results.push_back(quat_result(in_data));
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation waiting");
          mismatch_total++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.r_w !== exp_r.r_w) begin
            $error("r_w: expected %h, actual %h", exp_r.r_w, out_data.r_w);
            mismatch_total++;
          end
          if (out_data.r_x !== exp_r.r_x) begin
            $error("r_x: expected %h, actual %h", exp_r.r_x, out_data.r_x);
            mismatch_total++;
          end
          if (out_data.r_y !== exp_r.r_y) begin
            $error("r_y: expected %h, actual %h", exp_r.r_y, out_data.r_y);
            mismatch_total++;
          end
          if (out_data.r_z !== exp_r.r_z) begin
            $error("r_z: expected %h, actual %h", exp_r.r_z, out_data.r_z);
            mismatch_total++;
          end
          if (out_data.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_data.status);
            mismatch_total++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_quaternion_arithmetic_unit.sv =====
// Testbench top for the quaternion arithmetic unit: stimulus, pop stalls and verdict.
`timescale 1ns / 1ps
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam logic signed [31:0] ONE_Q = 32'sh1000_0000;
  localparam int RANDOM_ITEMS = 1330;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_t  in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   pop_hold = 0;

  always #2 clk = ~clk;

  quaternion_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  qau_result_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Picks a component value. The largest share of draws sits near unit scale so that divide,
  // normalize and rotate produce meaningful results; the rest cover the
  // full range, tiny values that round the norm to zero, and the extremes.
  function automatic logic signed [31:0] pick_component();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    if (sel < 70) return $urandom();
    if (sel < 85) return $signed($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000;
    if (sel < 90) return 32'sh7FFF_FFFF;
    if (sel < 95) return 32'sh8000_0000;
    return 0;
  endfunction

  // Waits out the transfer of one item, then may leave a random gap. The push
  // line is only lowered when a gap follows, so it is never toggled twice in
  // one time step.
  task automatic send_item(input in_t item, input bit allow_gap);
    int gap;
    int sel;
    in_data <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    gap = 0;
    if (allow_gap) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) gap = $urandom_range(1, 3);
      else if (sel < 18) gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [3:0] op,
                             input logic signed [31:0] aw, ax, ay, az,
                             input logic signed [31:0] bw, bx, by, bz);
    in_t item;
    item.cmd = op;
    item.a_w = aw; item.a_x = ax; item.a_y = ay; item.a_z = az;
    item.b_w = bw; item.b_x = bx; item.b_y = by; item.b_z = bz;
    send_item(item, 1'b1);
  endtask

  // The receiver pops most cycles, with short stalls and a few long ones.
  // Stretches of the run (while pop_hold is zero and the dice agree) pop
  // back to back so that the output queue also drains at full speed.
  always @(posedge clk) begin
    int sel;
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      out_pop <= 1'b0;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        pop_hold <= $urandom_range(0, 2);
        out_pop <= 1'b0;
      end else if (sel < 12) begin
        pop_hold <= $urandom_range(20, 80);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    #(4ns * 400000);
    $display("quaternion_arithmetic_unit test failed");
    $finish;
  end

  initial begin
    in_t item;
    int sel;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items: every opcode, most at unit scale, the extremes, the zero
    // divisor of divide, inverse and normalize, and the unused opcodes.
    send_fields(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1,
                32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1);
    send_fields(OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, ONE_Q,
                32'sh7FFF_FFFF, 32'sh8000_0000, ONE_Q, 0);
    send_fields(OP_SCALE, ONE_Q, -ONE_Q, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh8000_0000, 0, 0, 0);
    send_fields(OP_MUL, ONE_Q, ONE_Q >>> 1, -ONE_Q, 3,
                ONE_Q >>> 1, ONE_Q, ONE_Q, -7);
    send_fields(OP_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_fields(OP_DIV, ONE_Q, 2, 3, 4, ONE_Q, ONE_Q, 0, 0);
    send_fields(OP_DIV, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 0);
    send_fields(OP_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 100, 0, 0, 0);
    send_fields(OP_DIV, ONE_Q, 0, 0, 0, 1000, -1000, 1000, -1000);
    send_fields(OP_CONJ, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
    send_fields(OP_INV, ONE_Q, ONE_Q, 0, 0, 0, 0, 0, 0);
    send_fields(OP_INV, 5, -5, 16383, 0, 0, 0, 0, 0);
    send_fields(OP_INV, 20000, 0, 0, 0, 0, 0, 0, 0);
    send_fields(OP_DOT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_fields(OP_DOT, ONE_Q, 2, -3, 4, -ONE_Q, 5, 6, -7);
    send_fields(OP_ROT, 32'sh0B50_4F33, 0, 0, 32'sh0B50_4F33, 0, ONE_Q, 0, 0);
    send_fields(OP_ROT, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_fields(OP_NORM, 3 * ONE_Q / 2, 2 * ONE_Q / 2, 0, 0, 0, 0, 0, 0);
    send_fields(OP_NORM, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                0, 0, 0, 0);
    send_fields(OP_NORM, 100, -100, 50, 0, 0, 0, 0, 0);
    send_fields(OP_NORM, 16384, 0, 0, 0, 0, 0, 0, 0);
    send_fields(4'd10, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
    send_fields(4'd15, -1, -1, -1, -1, -1, -1, -1, -1);

    // Random items, mostly defined opcodes. Part way through the sender
    // holds off until the unit has drained completely.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      item.cmd = (sel < 94) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
      item.a_w = pick_component();
      item.a_x = pick_component();
      item.a_y = pick_component();
      item.a_z = pick_component();
      item.b_w = pick_component();
      item.b_x = pick_component();
      item.b_y = pick_component();
      item.b_z = pick_component();
      // Stretches without any sender gap keep the pipeline full.
      send_item(item, ((k / 100) % 3) != 1);
    end
    in_push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("quaternion_arithmetic_unit test passed");
    end else begin
      $display("quaternion_arithmetic_unit test failed");
    end
    $finish;
  end
endmodule

// ===== quaternion_arithmetic_unit.f =====
+incdir+sv
sv/qau_pkg.sv
sv/qau_fifo.sv
sv/qau_front.sv
sv/qau_back.sv
sv/quaternion_arithmetic_unit.sv
tb/sv/qau_result_checker.sv
tb/sv/tb_quaternion_arithmetic_unit.sv
